// ----- rtl/core/linked_queue_manager_core_defines.svh -----
// Assertion macros for the linked queue manager core
`ifndef LINKED_QUEUE_MANAGER_CORE_DEFINES_SVH
`define LINKED_QUEUE_MANAGER_CORE_DEFINES_SVH

// same-cycle implication
`define LQM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LQM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lqm_pkg.sv -----
// Shared constants and types of the linked queue manager
`timescale 1ns / 1ps
`default_nettype none

package lqm_pkg;

	localparam int NUM_ELEMENTS_DEF = 16;
	localparam int NUM_QUEUES_DEF   = 4;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_QUEUED = 2'd1,
		STATUS_EMPTY  = 2'd2,
		STATUS_NOT_IN = 2'd3
	} lqm_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_APP_TAIL,
		ST_APP_LINK,
		ST_REM_LINK,
		ST_DONE
	} lqm_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/lqm_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lqm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/linked_queue_manager_core.sv -----
// Top level of the linked queue manager: circular doubly linked queues over a slot pool
//
// Input channel (in_valid / in_ready) carries one command word: kind (append or
// remove), queue_id and elem_index. Output channel (out_valid / out_ready)
// returns one result word per command: status, queue_len, head_index and
// head_valid of the named queue after the command.
// Links, ownership and per-queue state live in four single-port-pair RAMs that
// a small sequencer drives from its states.
// After the accepting edge the sequencer goes from ST_CHECK to ST_DONE for
// errors and append to an empty queue, through ST_REM_LINK for remove, and
// through ST_APP_TAIL (tail lookup) and ST_APP_LINK (second link write) for
// append to a non-empty queue, the longest case; ST_DONE loads the output
// register. A new word is taken in the cycle after the result is loaded.
// After reset the block sweeps max(NUM_ELEMENTS, NUM_QUEUES) entries clearing
// the ownership and queue RAMs, with in_ready low.
// A finished result sits in the output register while in_ready is high again;
// if the receiver stalls, the next result waits in the sequencer until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "linked_queue_manager_core_defines.svh"

module linked_queue_manager_core #(
	parameter int NUM_ELEMENTS = lqm_pkg::NUM_ELEMENTS_DEF,
	parameter int NUM_QUEUES   = lqm_pkg::NUM_QUEUES_DEF,
	localparam int ElemW  = $clog2(NUM_ELEMENTS),
	localparam int QueueW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
	localparam int CountW = $clog2(NUM_ELEMENTS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              kind,
	input  wire logic [QueueW-1:0] queue_id,
	input  wire logic [ElemW-1:0]  elem_index,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             status,
	output logic [CountW-1:0]      queue_len,
	output logic [ElemW-1:0]       head_index,
	output logic                   head_valid
);

	localparam int ClrDepth = (NUM_ELEMENTS > NUM_QUEUES) ? NUM_ELEMENTS : NUM_QUEUES;
	localparam int ClrW     = $clog2(ClrDepth);
	localparam int OwnW     = 1 + QueueW;
	localparam int QstW     = 1 + ElemW + CountW;

	lqm_pkg::lqm_state_t state_q, state_d;

	logic [ClrW-1:0]   clr_q;
	logic              kind_q;
	logic [QueueW-1:0] qid_q;
	logic [ElemW-1:0]  elem_q;
	logic [ElemW-1:0]  head_q;
	logic [CountW-1:0] cnt_q;

	lqm_pkg::lqm_status_t res_status_q;
	logic [CountW-1:0]    res_size_q;
	logic [ElemW-1:0]     res_head_q;
	logic                 res_hv_q;

	logic                 out_valid_q;
	lqm_pkg::lqm_status_t out_status_q;
	logic [CountW-1:0]    out_size_q;
	logic [ElemW-1:0]     out_head_q;
	logic                 out_hv_q;

	logic              nxt_we, prv_we, own_we, qst_we;
	logic [ElemW-1:0]  nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
	logic [ElemW-1:0]  prv_waddr, prv_wdata, prv_raddr, prv_rdata;
	logic [ElemW-1:0]  own_waddr;
	logic [OwnW-1:0]   own_wdata, own_rdata;
	logic [QueueW-1:0] qst_waddr;
	logic [QstW-1:0]   qst_wdata, qst_rdata;

	logic              q_ok, e_ok;
	logic              rd_ne, rd_lk;
	logic [ElemW-1:0]  rd_head;
	logic [CountW-1:0] rd_cnt;
	logic [QueueW-1:0] rd_ow;
	logic              app_bad, rem_bad, out_load, clr_last;
	logic              rm_is_head, rm_last, rm_ne;
	logic [ElemW-1:0]  rm_head;
	logic [CountW-1:0] rm_cnt;

	lqm_ram #(.Width(ElemW), .Depth(NUM_ELEMENTS)) u_nxt_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(nxt_raddr), .rdata(nxt_rdata)
	);

	lqm_ram #(.Width(ElemW), .Depth(NUM_ELEMENTS)) u_prv_ram (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(prv_raddr), .rdata(prv_rdata)
	);

	lqm_ram #(.Width(OwnW), .Depth(NUM_ELEMENTS)) u_own_ram (
		.clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
		.raddr(elem_index), .rdata(own_rdata)
	);

	lqm_ram #(.Width(QstW), .Depth(NUM_QUEUES)) u_qst_ram (
		.clk(clk), .we(qst_we), .waddr(qst_waddr), .wdata(qst_wdata),
		.raddr(queue_id), .rdata(qst_rdata)
	);

	assign rd_ne   = qst_rdata[QstW-1];
	assign rd_head = qst_rdata[CountW +: ElemW];
	assign rd_cnt  = qst_rdata[CountW-1:0];
	assign rd_lk   = own_rdata[QueueW];
	assign rd_ow   = own_rdata[QueueW-1:0];

	assign q_ok     = (qid_q <= QueueW'(NUM_QUEUES - 1));
	assign e_ok     = (elem_q <= ElemW'(NUM_ELEMENTS - 1));
	assign app_bad  = !e_ok || rd_lk;
	assign rem_bad  = !e_ok || !rd_lk || (rd_ow != qid_q);
	assign out_load = (state_q == lqm_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign clr_last = (clr_q == ClrW'(ClrDepth - 1));

	assign rm_is_head = (head_q == elem_q);
	assign rm_last    = (nxt_rdata == elem_q);
	assign rm_ne      = !(rm_is_head && rm_last);
	assign rm_head    = rm_is_head ? (rm_last ? '0 : nxt_rdata) : head_q;
	assign rm_cnt     = (cnt_q != '0) ? (cnt_q - CountW'(1)) : cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lqm_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = lqm_pkg::ST_IDLE;
				end
			end
			lqm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lqm_pkg::ST_CHECK;
				end
			end
			lqm_pkg::ST_CHECK: begin
				priority if (!q_ok) begin
					state_d = lqm_pkg::ST_DONE;
				end else if (kind_q == lqm_pkg::KIND_APPEND) begin
					state_d = (!app_bad && rd_ne) ? lqm_pkg::ST_APP_TAIL : lqm_pkg::ST_DONE;
				end else begin
					state_d = (rd_ne && !rem_bad) ? lqm_pkg::ST_REM_LINK : lqm_pkg::ST_DONE;
				end
			end
			lqm_pkg::ST_APP_TAIL: state_d = lqm_pkg::ST_APP_LINK;
			lqm_pkg::ST_APP_LINK: state_d = lqm_pkg::ST_DONE;
			lqm_pkg::ST_REM_LINK: state_d = lqm_pkg::ST_DONE;
			lqm_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = lqm_pkg::ST_IDLE;
				end
			end
			default: state_d = lqm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		nxt_we    = 1'b0;
		nxt_waddr = elem_q;
		nxt_wdata = elem_q;
		prv_we    = 1'b0;
		prv_waddr = elem_q;
		prv_wdata = elem_q;
		own_we    = 1'b0;
		own_waddr = elem_q;
		own_wdata = {1'b1, qid_q};
		qst_we    = 1'b0;
		qst_waddr = qid_q;
		qst_wdata = {1'b1, elem_q, rd_cnt + CountW'(1)};
		nxt_raddr = elem_q;
		prv_raddr = (kind_q == lqm_pkg::KIND_APPEND) ? rd_head : elem_q;
		unique case (state_q)
			lqm_pkg::ST_CLEAR: begin
				own_we    = (clr_q <= ClrW'(NUM_ELEMENTS - 1));
				own_waddr = clr_q[ElemW-1:0];
				own_wdata = '0;
				qst_we    = (clr_q <= ClrW'(NUM_QUEUES - 1));
				qst_waddr = clr_q[QueueW-1:0];
				qst_wdata = '0;
			end
			lqm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			lqm_pkg::ST_CHECK: begin
				if (q_ok && kind_q == lqm_pkg::KIND_APPEND && !app_bad && !rd_ne) begin
					nxt_we = 1'b1;
					prv_we = 1'b1;
					own_we = 1'b1;
					qst_we = 1'b1;
				end
			end
			lqm_pkg::ST_APP_TAIL: begin
				nxt_we    = 1'b1;
				nxt_waddr = prv_rdata;
				prv_we    = 1'b1;
				prv_wdata = prv_rdata;
				own_we    = 1'b1;
				qst_we    = 1'b1;
				qst_wdata = {1'b1, head_q, cnt_q + CountW'(1)};
			end
			lqm_pkg::ST_APP_LINK: begin
				nxt_we    = 1'b1;
				nxt_wdata = head_q;
				prv_we    = 1'b1;
				prv_waddr = head_q;
			end
			lqm_pkg::ST_REM_LINK: begin
				nxt_we    = 1'b1;
				nxt_waddr = prv_rdata;
				nxt_wdata = nxt_rdata;
				prv_we    = 1'b1;
				prv_waddr = nxt_rdata;
				prv_wdata = prv_rdata;
				own_we    = 1'b1;
				own_wdata = {1'b0, qid_q};
				qst_we    = 1'b1;
				qst_wdata = {rm_ne, rm_head, rm_cnt};
			end
			lqm_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lqm_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lqm_pkg::ST_CLEAR) begin
				clr_q <= clr_q + ClrW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind;
			qid_q  <= queue_id;
			elem_q <= elem_index;
		end
		if (state_q == lqm_pkg::ST_CHECK) begin
			head_q <= rd_head;
			cnt_q  <= rd_cnt;
			priority if (!q_ok) begin
				res_status_q <= lqm_pkg::STATUS_EMPTY;
				res_size_q   <= '0;
				res_head_q   <= '0;
				res_hv_q     <= 1'b0;
			end else if (kind_q == lqm_pkg::KIND_APPEND && !app_bad && !rd_ne) begin
				res_status_q <= lqm_pkg::STATUS_OK;
				res_size_q   <= rd_cnt + CountW'(1);
				res_head_q   <= elem_q;
				res_hv_q     <= 1'b1;
			end else begin
				priority if (kind_q == lqm_pkg::KIND_APPEND) begin
					res_status_q <= app_bad ? lqm_pkg::STATUS_QUEUED : lqm_pkg::STATUS_OK;
				end else if (!rd_ne) begin
					res_status_q <= lqm_pkg::STATUS_EMPTY;
				end else begin
					res_status_q <= rem_bad ? lqm_pkg::STATUS_NOT_IN : lqm_pkg::STATUS_OK;
				end
				res_size_q <= rd_cnt;
				res_head_q <= rd_ne ? rd_head : '0;
				res_hv_q   <= rd_ne;
			end
		end
		if (state_q == lqm_pkg::ST_APP_TAIL) begin
			res_size_q <= cnt_q + CountW'(1);
			res_head_q <= head_q;
			res_hv_q   <= 1'b1;
		end
		if (state_q == lqm_pkg::ST_REM_LINK) begin
			res_size_q <= rm_cnt;
			res_head_q <= rm_ne ? rm_head : '0;
			res_hv_q   <= rm_ne;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_size_q   <= res_size_q;
			out_head_q   <= res_head_q;
			out_hv_q     <= res_hv_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign queue_len  = out_size_q;
	assign head_index = out_head_q;
	assign head_valid = out_hv_q;

	`LQM_ASSERT_NEXT(a_accept_to_check, clk, arst_n, in_valid && in_ready, state_q == lqm_pkg::ST_CHECK, "accepted word did not start a check")
	`LQM_ASSERT_NEXT(a_done_holds, clk, arst_n, (state_q == lqm_pkg::ST_DONE) && out_valid_q && !out_ready, state_q == lqm_pkg::ST_DONE, "result left sequencer while output stalled")
	`LQM_ASSERT_NOW(a_empty_size, clk, arst_n, out_valid && !head_valid, queue_len == '0, "empty queue reports nonzero size")
	`LQM_ASSERT_NOW(a_empty_head, clk, arst_n, out_valid && !head_valid, head_index == '0, "empty queue reports nonzero head")

endmodule

`default_nettype wire
